### hdl/alq_pkg.sv
// ---------------------------------------------------------------------------
// alq_pkg: shared types and constants for the CAN transmit admission queue
// Request/response item layouts, status codes and the front-to-back command.
// ---------------------------------------------------------------------------
package alq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int CMDQ_DEPTH      = 2;
  localparam int RESQ_DEPTH      = 2;

  localparam int ID_W    = 29;
  localparam int FLAGS_W = 8;
  localparam int DLC_W   = 4;
  localparam int DATA_W  = 64;
  localparam int CNT_W   = 5;

  localparam logic [ID_W-1:0]    STD_ID_MAX = ID_W'(32'h0000_07FF);
  localparam logic [ID_W-1:0]    EXT_ID_MAX = ID_W'(32'h1FFF_FFFF);
  localparam logic [DLC_W-1:0]   DLC_MAX    = DLC_W'(8);
  localparam logic [FLAGS_W-1:0] FLAG_EXT   = FLAGS_W'(1);

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_POP     = 2'd1,
    OP_PURGE   = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DISABLED  = 3'd1,
    ST_BAD_FLAGS = 3'd2,
    ST_BAD_ID    = 3'd3,
    ST_BAD_DLC   = 3'd4,
    ST_FULL      = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    CMD_ENQ,
    CMD_POP,
    CMD_PURGE,
    CMD_NOP,
    CMD_REJECT
  } cmd_kind_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [ID_W-1:0]     can_id;
    logic [FLAGS_W-1:0]  frame_flags;
    logic [DLC_W-1:0]    data_length;
    logic [DATA_W-1:0]   payload;
  } request_t;

  typedef struct packed {
    status_t             status;
    logic [ID_W-1:0]     out_can_id;
    logic                out_extended;
    logic [DLC_W-1:0]    out_length;
    logic [DATA_W-1:0]   out_payload;
    logic [CNT_W-1:0]    purged_count;
    logic [CNT_W-1:0]    occupancy;
  } response_t;

  // Stored frame header: dlc, extended flag, id
  typedef struct packed {
    logic [DLC_W-1:0]    dlc;
    logic                ext;
    logic [ID_W-1:0]     id;
  } header_t;

  localparam int SLOT_W = $bits(header_t) + DATA_W;

  typedef struct packed {
    cmd_kind_t           kind;
    status_t             status;
    header_t             header;
    logic [DATA_W-1:0]   data;
  } cmd_t;

endpackage

### hdl/alq_ram.sv
// ---------------------------------------------------------------------------
// alq_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module alq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/alq_fifo.sv
// ---------------------------------------------------------------------------
// alq_fifo: small register queue
// Decouples two sides of the datapath; head item shown while not empty.
// ---------------------------------------------------------------------------
module alq_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T              slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/alq_front.sv
// ---------------------------------------------------------------------------
// alq_front: request intake and admission checks
// Holds the transmit enable, classifies each request and queues a command.
// ---------------------------------------------------------------------------
module alq_front
  import alq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  input  logic     push,
  input  request_t request,
  output logic     full,
  input  logic     cmd_pop,
  output cmd_t     cmd,
  output logic     cmd_empty
);

  logic            transmit_enable;
  cmd_t            cls;
  logic            ext;
  logic [ID_W-1:0] id_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      transmit_enable <= 1'b1;
    end else if (cfg_we) begin
      transmit_enable <= cfg_wdata;
    end
  end

  assign ext    = request.frame_flags[0];
  assign id_max = ext ? EXT_ID_MAX : STD_ID_MAX;

  // Everything but the full/empty checks is decided here.
  always_comb begin
    cls.kind        = CMD_NOP;
    cls.status      = ST_OK;
    cls.header.id   = request.can_id;
    cls.header.ext  = ext;
    cls.header.dlc  = request.data_length;
    cls.data        = request.payload;
    case (request.opcode)
      OP_ENQUEUE: begin
        cls.kind = CMD_REJECT;
        if (!transmit_enable) begin
          cls.status = ST_DISABLED;
        end else if ((request.frame_flags & ~FLAG_EXT) != '0) begin
          cls.status = ST_BAD_FLAGS;
        end else if (request.can_id > id_max) begin
          cls.status = ST_BAD_ID;
        end else if (request.data_length > DLC_MAX) begin
          cls.status = ST_BAD_DLC;
        end else begin
          cls.kind = CMD_ENQ;
        end
      end
      OP_POP: begin
        if (!transmit_enable) begin
          cls.kind   = CMD_REJECT;
          cls.status = ST_DISABLED;
        end else begin
          cls.kind = CMD_POP;
        end
      end
      OP_PURGE: cls.kind = CMD_PURGE;
      default:  cls.kind = CMD_NOP;
    endcase
  end

  alq_fifo #(
    .T     (cmd_t),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cls),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty)
  );

endmodule

### hdl/alq_back.sv
// ---------------------------------------------------------------------------
// alq_back: frame ring engine
// Executes queued commands against the frame ring and produces responses.
// ---------------------------------------------------------------------------
module alq_back
  import alq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  logic      cmd_empty,
  output logic      cmd_pop,
  output logic      res_push,
  output response_t res,
  input  logic      res_full
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    S_DISPATCH,
    S_READ
  } state_t;

  state_t              state;
  logic [PW-1:0]       rd_ptr;
  logic [PW-1:0]       wr_ptr;
  logic [CW-1:0]       count;
  logic                go;
  logic                ring_full;
  logic                ring_empty;
  logic                do_write;
  logic                do_read;
  logic [SLOT_W-1:0]   rd_slot;
  header_t             rd_hdr;
  logic [DATA_W-1:0]   rd_data;

  assign ring_full  = (count == CW'(QUEUE_DEPTH));
  assign ring_empty = (count == '0);
  assign go         = (state == S_DISPATCH) && !cmd_empty && !res_full;
  assign cmd_pop    = go;
  assign do_write   = go && (cmd.kind == CMD_ENQ) && !ring_full;
  assign do_read    = go && (cmd.kind == CMD_POP) && !ring_empty;
  assign {rd_hdr, rd_data} = rd_slot;

  alq_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (do_write),
    .waddr (wr_ptr),
    .wdata ({cmd.header, cmd.data}),
    .re    (do_read),
    .raddr (rd_ptr),
    .rdata (rd_slot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_DISPATCH;
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      case (state)
        S_DISPATCH: begin
          if (do_write) begin
            wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
            count  <= count + CW'(1);
          end
          if (do_read) begin
            rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
            count  <= count - CW'(1);
            state  <= S_READ;
          end
          if (go && cmd.kind == CMD_PURGE) begin
            rd_ptr <= '0;
            wr_ptr <= '0;
            count  <= '0;
          end
        end
        S_READ:  state <= S_DISPATCH;
        default: state <= S_DISPATCH;
      endcase
    end
  end

  // Response build; a successful pop reports in the next cycle, from S_READ, with RAM data.
  always_comb begin
    res_push         = 1'b0;
    res.status       = ST_OK;
    res.out_can_id   = '0;
    res.out_extended = 1'b0;
    res.out_length   = '0;
    res.out_payload  = '0;
    res.purged_count = '0;
    res.occupancy    = CNT_W'(count);
    if (state == S_READ) begin
      res_push         = 1'b1;
      res.out_can_id   = rd_hdr.id;
      res.out_extended = rd_hdr.ext;
      res.out_length   = rd_hdr.dlc;
      res.out_payload  = rd_data;
    end else if (go) begin
      case (cmd.kind)
        CMD_ENQ: begin
          res_push = 1'b1;
          if (ring_full) begin
            res.status = ST_FULL;
          end else begin
            res.occupancy = CNT_W'(count + CW'(1));
          end
        end
        CMD_POP: begin
          // successful pop responds from S_READ
          if (ring_empty) begin
            res_push   = 1'b1;
            res.status = ST_EMPTY;
          end
        end
        CMD_PURGE: begin
          res_push         = 1'b1;
          res.purged_count = CNT_W'(count);
          res.occupancy    = '0;
        end
        CMD_REJECT: begin
          res_push   = 1'b1;
          res.status = cmd.status;
        end
        default: res_push = 1'b1;
      endcase
    end
  end

endmodule

### hdl/can_tx_admission_queue.sv
// A request is registered in the command queue, its response in the response
// queue; a pop returning a frame adds the registered ring read (S_READ), where
// no new command is taken. The ring engine is the limit: one request per cycle
// otherwise while responses drain; command and response queues absorb stalls.
// Reset: pointers and counts clear, transmit enable sets; ring contents kept.
// ---------------------------------------------------------------------------
// can_tx_admission_queue: CAN transmit queue with frame admission checks
// Front checks and queues requests, back runs them against the frame ring.
// ---------------------------------------------------------------------------
module can_tx_admission_queue
  import alq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      push,
  input  request_t  request,
  output logic      full,
  input  logic      pop,
  output response_t response,
  output logic      empty
);

  cmd_t      cmd;
  logic      cmd_empty;
  logic      cmd_pop;
  logic      res_push;
  response_t res;
  logic      res_full;

  alq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .request   (request),
    .full      (full),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  alq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  alq_fifo #(
    .T     (response_t),
    .DEPTH (RESQ_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (response),
    .empty (empty)
  );

endmodule

### tb/tb_can_tx_admission_queue.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_can_tx_admission_queue: self-checking bench for the CAN transmit queue
// Drives enqueue, pop, purge and no-op requests through the push/full side,
// mirrors the frame ring and the admission checks in a local copy of the
// queue state, and compares every response popped from the result side.
// ---------------------------------------------------------------------------
module tb_can_tx_admission_queue;
  import alq_pkg::*;

  localparam int RING_DEPTH      = QUEUE_DEPTH_DEF;
  localparam int RX_HOLD_CYCLES  = 300;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 10;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;
  logic      push = 1'b0;
  request_t  request = '0;
  logic      full;
  logic      pop = 1'b0;
  response_t response;
  logic      empty;

  can_tx_admission_queue i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .request   (request),
    .full      (full),
    .pop       (pop),
    .response  (response),
    .empty     (empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the ring and the enable register
  header_t           header_ring [RING_DEPTH];
  logic [DATA_W-1:0] payload_ring [RING_DEPTH];
  int                ring_rd = 0;
  int                ring_wr = 0;
  int                ring_held = 0;
  logic              tx_enable_model = 1'b1;

  response_t         awaited_responses [$];
  int                mismatches = 0;
  int                idle_cycles = 0;
  bit                sender_no_gaps = 1'b0;
  bit                holdoff_armed = 1'b0;
  bit                holdoff_active = 1'b0;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Applies one request to the local ring and returns the response it gives
  function automatic response_t ring_apply_op(input request_t req);
    response_t r;
    logic      ext;
    r = '0;
    r.status = ST_OK;
    ext = req.frame_flags[0];
    case (req.opcode)
      OP_ENQUEUE: begin
        if (!tx_enable_model) r.status = ST_DISABLED;
        else if ((req.frame_flags & ~FLAG_EXT) != '0) r.status = ST_BAD_FLAGS;
        else if (req.can_id > (ext ? EXT_ID_MAX : STD_ID_MAX)) r.status = ST_BAD_ID;
        else if (req.data_length > DLC_MAX) r.status = ST_BAD_DLC;
        else if (ring_held >= RING_DEPTH) r.status = ST_FULL;
        else begin
          header_ring[ring_wr].id = req.can_id;
          header_ring[ring_wr].ext = ext;
          header_ring[ring_wr].dlc = req.data_length;
          payload_ring[ring_wr] = req.payload;
          ring_wr = (ring_wr + 1) % RING_DEPTH;
          ring_held++;
        end
      end
      OP_POP: begin
        if (!tx_enable_model) r.status = ST_DISABLED;
        else if (ring_held == 0) r.status = ST_EMPTY;
        else begin
          r.out_can_id = header_ring[ring_rd].id;
          r.out_extended = header_ring[ring_rd].ext;
          r.out_length = header_ring[ring_rd].dlc;
          r.out_payload = payload_ring[ring_rd];
          ring_rd = (ring_rd + 1) % RING_DEPTH;
          ring_held--;
        end
      end
      OP_PURGE: begin
        r.purged_count = CNT_W'(ring_held);
        ring_held = 0;
        ring_rd = 0;
        ring_wr = 0;
      end
      default: ;
    endcase
    r.occupancy = CNT_W'(ring_held);
    return r;
  endfunction

  function automatic request_t make_request(input opcode_t op, input logic [ID_W-1:0] id,
                                            input logic [FLAGS_W-1:0] flags,
                                            input logic [DLC_W-1:0] dlc,
                                            input logic [DATA_W-1:0] data);
    request_t req;
    req.opcode = op;
    req.can_id = id;
    req.frame_flags = flags;
    req.data_length = dlc;
    req.payload = data;
    return req;
  endfunction

  // Enqueued frames: mostly well-formed, the rest break one field or are noise
  function automatic request_t random_request(input int enqueue_pct);
    request_t req;
    int       pick;
    req.can_id = ID_W'($urandom);
    req.frame_flags = FLAGS_W'($urandom);
    req.data_length = DLC_W'($urandom);
    req.payload = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < enqueue_pct) begin
      req.opcode = OP_ENQUEUE;
      req.frame_flags = FLAGS_W'($urandom_range(0, 1));
      req.can_id = req.frame_flags[0] ? ID_W'($urandom) : ID_W'($urandom_range(0, STD_ID_MAX));
      if ($urandom_range(0, 7) == 0)
        req.can_id = req.frame_flags[0] ? EXT_ID_MAX : STD_ID_MAX;
      req.data_length = DLC_W'($urandom_range(0, DLC_MAX));
      if ($urandom_range(0, 9) < 2) begin
        case ($urandom_range(0, 3))
          0: req.frame_flags = FLAGS_W'($urandom);
          1: begin
            req.frame_flags = '0;
            req.can_id = ($urandom_range(0, 3) == 0) ? STD_ID_MAX + 1'b1 :
                         ID_W'($urandom_range(STD_ID_MAX + 1, EXT_ID_MAX));
          end
          2: req.data_length = DLC_W'($urandom_range(DLC_MAX + 1, 15));
          default: begin
            req.can_id = ID_W'($urandom);
            req.frame_flags = FLAGS_W'($urandom);
            req.data_length = DLC_W'($urandom);
          end
        endcase
      end
    end else if (pick < 92) begin
      req.opcode = OP_POP;
    end else if (pick < 96) begin
      req.opcode = OP_PURGE;
    end else begin
      req.opcode = OP_NOP;
    end
    return req;
  endfunction

  task automatic send_request(input request_t req);
    int gap;
    gap = sender_no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    request <= req;
    @(posedge clk);
    while (full) @(posedge clk);
    awaited_responses.push_back(ring_apply_op(req));
  endtask

  // Only written with the queue drained and nothing offered
  task automatic set_transmit_enable(input logic value);
    push <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tx_enable_model = value;
  endtask

  task automatic test_admission_checks();
    send_request(make_request(OP_POP, '0, '0, '0, '0));
    send_request(make_request(OP_ENQUEUE, STD_ID_MAX, '0, DLC_MAX, '1));
    send_request(make_request(OP_ENQUEUE, '0, '0, '0, 64'h0123_4567_89AB_CDEF));
    send_request(make_request(OP_ENQUEUE, STD_ID_MAX + 1'b1, '0, 4'd1, '0));
    send_request(make_request(OP_ENQUEUE, EXT_ID_MAX, FLAG_EXT, '0, '0));
    // flags are checked ahead of id and dlc
    send_request(make_request(OP_ENQUEUE, '1, 8'h02, '1, '1));
    send_request(make_request(OP_ENQUEUE, '0, 8'hFF, '0, '0));
    send_request(make_request(OP_ENQUEUE, '0, 8'h80, '0, '0));
    // id ahead of dlc
    send_request(make_request(OP_ENQUEUE, STD_ID_MAX + 1'b1, '0, 4'd9, '0));
    send_request(make_request(OP_ENQUEUE, STD_ID_MAX, '0, 4'd9, '0));
    send_request(make_request(OP_ENQUEUE, EXT_ID_MAX, FLAG_EXT, '1, '1));
    send_request(make_request(OP_NOP, '1, '1, '1, '1));
    send_request(make_request(OP_POP, '1, '1, '1, '1));
    send_request(make_request(OP_POP, '0, '0, '0, '0));
    send_request(make_request(OP_POP, '0, '0, '0, '0));
    send_request(make_request(OP_POP, '0, '0, '0, '0));
    send_request(make_request(OP_ENQUEUE, ID_W'(11'h555), '0, 4'd4, 64'hA5));
    send_request(make_request(OP_ENQUEUE, ID_W'(29'h0AAA_AAAA), FLAG_EXT, 4'd2, 64'h5A));
    send_request(make_request(OP_PURGE, '1, '1, '1, '1));
    send_request(make_request(OP_POP, '0, '0, '0, '0));
    send_request(make_request(OP_PURGE, '0, '0, '0, '0));
  endtask

  task automatic test_transmit_disabled();
    send_request(make_request(OP_ENQUEUE, ID_W'(11'h123), '0, 4'd3, 64'h11));
    send_request(make_request(OP_ENQUEUE, ID_W'(29'h1234_5678), FLAG_EXT, 4'd8, 64'h22));
    set_transmit_enable(1'b0);
    send_request(make_request(OP_ENQUEUE, ID_W'(11'h321), '0, 4'd1, 64'h33));
    send_request(make_request(OP_ENQUEUE, '1, 8'hFE, '1, '1));
    send_request(make_request(OP_POP, '0, '0, '0, '0));
    send_request(make_request(OP_NOP, '0, '0, '0, '0));
    send_request(make_request(OP_PURGE, '0, '0, '0, '0));
    send_request(make_request(OP_POP, '0, '0, '0, '0));
    set_transmit_enable(1'b1);
    send_request(make_request(OP_POP, '0, '0, '0, '0));
  endtask

  // Receiver stops popping while requests keep coming, so the response queue
  // fills and the input side backs up
  task automatic test_receiver_holdoff();
    push <= 1'b0;
    holdoff_armed = 1'b1;
    while (!holdoff_active) @(posedge clk);
    sender_no_gaps = 1'b1;
    send_request(make_request(OP_PURGE, '0, '0, '0, '0));
    repeat (RING_DEPTH + 4) send_request(random_request(100));
    repeat (8) send_request(random_request(0));
    sender_no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    int enqueue_mix [7] = '{50, 70, 30, 50, 60, 40, 50};
    int count;
    for (int phase = 0; phase < 7; phase++) begin
      set_transmit_enable(phase != 3);
      sender_no_gaps = (phase == 2 || phase == 5);
      count = (phase == 3) ? 100 : 275;
      repeat (count) send_request(random_request(enqueue_mix[phase]));
    end
    sender_no_gaps = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_response
    response_t want;
    if (!rst && pop && !empty) begin
      if (awaited_responses.size() == 0) begin
        $error("response transfer with nothing awaited");
        mismatches++;
      end else begin
        want = awaited_responses.pop_front();
        check_field("status", want.status, response.status);
        check_field("out_can_id", want.out_can_id, response.out_can_id);
        check_field("out_extended", want.out_extended, response.out_extended);
        check_field("out_length", want.out_length, response.out_length);
        check_field("out_payload", want.out_payload, response.out_payload);
        check_field("purged_count", want.purged_count, response.purged_count);
        check_field("occupancy", want.occupancy, response.occupancy);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin : drain_side
    int run;
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (holdoff_armed) begin
        holdoff_armed = 1'b0;
        holdoff_active = 1'b1;
        pop <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        holdoff_active = 1'b0;
      end
      // mostly short bursts, now and then a long stretch with no stall
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      pop <= 1'b1;
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_admission_checks();
    test_transmit_disabled();
    test_receiver_holdoff();
    test_random_traffic();
    push <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

### can_tx_admission_queue.f
hdl/alq_pkg.sv
hdl/alq_ram.sv
hdl/alq_fifo.sv
hdl/alq_front.sv
hdl/alq_back.sv
hdl/can_tx_admission_queue.sv
tb/tb_can_tx_admission_queue.sv
